// ===== rtl/core/tsvf_pkg.sv =====
package tsvf_pkg;

  // Register widths and fixed-point formats
  localparam int GAIN_W      = 25;  // g, Q5.20
  localparam int DAMP_W      = 17;  // r, Q1.16
  localparam int SCALE_W     = 25;  // h, Q1.24
  localparam int GAIN_FRAC   = 20;
  localparam int SCALE_FRAC  = 24;
  localparam int DAMP_SHIFT  = GAIN_FRAC - 15;  // r is Q1.16, so 2r in Q.20 is r << 5
  localparam int COEF_W      = 26;  // 2r + g in Q.20
  localparam int LO_W        = 24;  // low half of a split product
  localparam int CFG_DATA_W  = 25;
  localparam int CFG_IDX_W   = 2;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(0);
  localparam logic [DAMP_W-1:0]  DAMP_RST  = DAMP_W'(65536);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(16777216);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF_GAIN    = 2'd0,
    REG_DAMPING        = 2'd1,
    REG_FEEDBACK_SCALE = 2'd2
  } reg_idx_e;

  // Which product the shared multiplier is working on
  typedef enum logic [1:0] {
    PASS_FB = 2'd0,  // s1 * (2r + g)
    PASS_HP = 2'd1,  // acc * h
    PASS_BP = 2'd2,  // hp * g
    PASS_LP = 2'd3   // bp * g
  } pass_e;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_LOAD = 11'b000_0000_0010,
    S_MLO  = 11'b000_0000_0100,
    S_MHI  = 11'b000_0000_1000,
    S_ACC  = 11'b000_0001_0000,
    S_HP   = 11'b000_0010_0000,
    S_BP   = 11'b000_0100_0000,
    S_S1   = 11'b000_1000_0000,
    S_LP   = 11'b001_0000_0000,
    S_S2   = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic  load_x;
    logic  load_op;
    logic  mul_lo;
    logic  mul_hi;
    logic  upd_acc;
    logic  upd_hp;
    logic  upd_bp;
    logic  upd_s1;
    logic  upd_lp;
    logic  upd_s2;
    logic  out_load;
    pass_e pass;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/core/tsvf_in_if.sv =====
interface tsvf_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/tsvf_out_if.sv =====
interface tsvf_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] lowpass_out;
  logic signed [SAMPLE_WIDTH-1:0] bandpass_out;
  logic signed [SAMPLE_WIDTH-1:0] highpass_out;

  modport source (output valid, output lowpass_out, output bandpass_out,
                  output highpass_out, input ready);
  modport sink   (input valid, input lowpass_out, input bandpass_out,
                  input highpass_out, output ready);
endinterface

// ===== rtl/core/tsvf_ctrl.sv =====
module tsvf_ctrl import tsvf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    cmd_o.pass = pass_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          pass_d       = PASS_FB;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load_op = 1'b1;
        state_d       = S_MLO;
      end
      S_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_hi = 1'b1;
        unique case (pass_q)
          PASS_FB: state_d = S_ACC;
          PASS_HP: state_d = S_HP;
          PASS_BP: state_d = S_BP;
          PASS_LP: state_d = S_LP;
          default: state_d = S_IDLE;
        endcase
      end
      S_ACC: begin
        cmd_o.upd_acc = 1'b1;
        pass_d        = PASS_HP;
        state_d       = S_LOAD;
      end
      S_HP: begin
        cmd_o.upd_hp = 1'b1;
        pass_d       = PASS_BP;
        state_d      = S_LOAD;
      end
      S_BP: begin
        cmd_o.upd_bp = 1'b1;
        state_d      = S_S1;
      end
      S_S1: begin
        cmd_o.upd_s1 = 1'b1;
        pass_d       = PASS_LP;
        state_d      = S_LOAD;
      end
      S_LP: begin
        cmd_o.upd_lp = 1'b1;
        state_d      = S_S2;
      end
      S_S2: begin
        cmd_o.upd_s2 = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // wait until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= PASS_FB;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule

// ===== rtl/core/tsvf_datapath.sv =====
module tsvf_datapath import tsvf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cmd_t                           cmd_i,
  output status_t                        status_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] lowpass_o,
  output logic signed [SAMPLE_WIDTH-1:0] bandpass_o,
  output logic signed [SAMPLE_WIDTH-1:0] highpass_o
);

  // acc = x - s1*(2r+g) - s2 stays below 2^(STATE_WIDTH+6) in magnitude
  localparam int ACC_W = STATE_WIDTH + 7;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int A_W   = (HI_W > LO_W) ? HI_W : LO_W;
  localparam int PW    = ACC_W + COEF_W;
  localparam int R_W   = STATE_WIDTH + 8;
  localparam int R1_W  = R_W + 1;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [R1_W-1:0] v
  );
    logic [R1_W-STATE_WIDTH:0] top;
    top = v[R1_W-1:STATE_WIDTH-1];
    if (top == '0 || top == '1) return v[STATE_WIDTH-1:0];
    else if (v[R1_W-1]) return {1'b1, {(STATE_WIDTH-1){1'b0}}};
    else return {1'b0, {(STATE_WIDTH-1){1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(
    input logic signed [STATE_WIDTH-1:0] v
  );
    logic [STATE_WIDTH-SAMPLE_WIDTH:0] top;
    top = v[STATE_WIDTH-1:SAMPLE_WIDTH-1];
    if (top == '0 || top == '1) return v[SAMPLE_WIDTH-1:0];
    else if (v[STATE_WIDTH-1]) return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    else return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  endfunction

  logic [GAIN_W-1:0]  cutoff_gain_q;
  logic [DAMP_W-1:0]  damping_q;
  logic [SCALE_W-1:0] feedback_scale_q;
  logic [COEF_W-1:0]  coef_w;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [STATE_WIDTH-1:0]  s1_q, s2_q, hp_q, bp_q, lp_q;
  logic signed [ACC_W-1:0]        acc_q;

  logic signed [ACC_W-1:0] op_src;
  logic [ACC_W-1:0]        mag_q, mag_d;
  logic                    neg_q;
  logic [COEF_W-1:0]       b_q, b_d;
  logic                    scale_q, scale_d;

  logic [A_W-1:0]          mul_a;
  logic [A_W+COEF_W-1:0]   mul_p;
  logic [PW-1:0]           half_w;
  logic [PW-1:0]           pr_q;
  logic [R_W-2:0]          p_w;
  logic signed [R_W-1:0]   r_w;

  logic signed [STATE_WIDTH-1:0] addend;
  logic signed [STATE_WIDTH-1:0] upd_w;
  logic signed [R1_W-1:0]        acc_sum;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] lowpass_q, bandpass_q, highpass_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_gain_q    <= GAIN_RST;
      damping_q        <= DAMP_RST;
      feedback_scale_q <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CUTOFF_GAIN:    cutoff_gain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_DAMPING:        damping_q        <= cfg_data_i[DAMP_W-1:0];
        REG_FEEDBACK_SCALE: feedback_scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign coef_w = (COEF_W'(damping_q) << DAMP_SHIFT) + COEF_W'(cutoff_gain_q);

  // operand load: sign/magnitude split and coefficient select
  always_comb begin
    unique case (cmd_i.pass)
      PASS_FB: begin
        op_src  = ACC_W'(s1_q);
        b_d     = coef_w;
        scale_d = 1'b0;
      end
      PASS_HP: begin
        op_src  = acc_q;
        b_d     = COEF_W'(feedback_scale_q);
        scale_d = 1'b1;
      end
      PASS_BP: begin
        op_src  = ACC_W'(hp_q);
        b_d     = COEF_W'(cutoff_gain_q);
        scale_d = 1'b0;
      end
      PASS_LP: begin
        op_src  = ACC_W'(bp_q);
        b_d     = COEF_W'(cutoff_gain_q);
        scale_d = 1'b0;
      end
      default: begin
        op_src  = '0;
        b_d     = '0;
        scale_d = 1'b0;
      end
    endcase
    mag_d = op_src[ACC_W-1] ? ACC_W'(-op_src) : op_src;
  end

  // one shared multiplier, low half then high half of the magnitude
  always_comb begin
    if (cmd_i.mul_hi) mul_a = A_W'(mag_q[ACC_W-1:LO_W]);
    else mul_a = A_W'(mag_q[LO_W-1:0]);
  end

  assign mul_p  = mul_a * b_q;
  assign half_w = scale_q ? (PW'(1) << (SCALE_FRAC - 1)) : (PW'(1) << (GAIN_FRAC - 1));

  // round half away from zero on the magnitude, then restore the sign
  assign p_w = scale_q ? pr_q[SCALE_FRAC +: R_W-1] : pr_q[GAIN_FRAC +: R_W-1];
  assign r_w = neg_q ? -$signed({1'b0, p_w}) : $signed({1'b0, p_w});

  always_comb begin
    if (cmd_i.upd_bp) addend = s1_q;
    else if (cmd_i.upd_s1) addend = bp_q;
    else if (cmd_i.upd_lp) addend = s2_q;
    else if (cmd_i.upd_s2) addend = lp_q;
    else addend = '0;
  end

  assign upd_w   = sat_state(R1_W'(r_w) + R1_W'(addend));
  assign acc_sum = R1_W'(x_q) - R1_W'(r_w) - R1_W'(s2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) x_q <= sample_i;
    if (cmd_i.load_op) begin
      mag_q   <= mag_d;
      neg_q   <= op_src[ACC_W-1];
      b_q     <= b_d;
      scale_q <= scale_d;
    end
    if (cmd_i.mul_lo) pr_q <= PW'(mul_p) + half_w;
    else if (cmd_i.mul_hi) pr_q <= pr_q + (PW'(mul_p) << LO_W);
    if (cmd_i.upd_acc) acc_q <= ACC_W'(acc_sum);
    if (cmd_i.upd_hp) hp_q <= upd_w;
    if (cmd_i.upd_bp) bp_q <= upd_w;
    if (cmd_i.upd_lp) lp_q <= upd_w;
    if (cmd_i.out_load) begin
      lowpass_q  <= sat_out(lp_q);
      bandpass_q <= sat_out(bp_q);
      highpass_q <= sat_out(hp_q);
    end
  end

  // integrator states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      if (cmd_i.upd_s1) s1_q <= upd_w;
      if (cmd_i.upd_s2) s2_q <= upd_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign lowpass_o         = lowpass_q;
  assign bandpass_o        = bandpass_q;
  assign highpass_o        = highpass_q;

endmodule

// ===== rtl/core/tpt_state_variable_filter_top.sv =====
// Trapezoidal-integrator state variable filter: each request carries one
// signed Q1.23 sample and yields one result with saturated lowpass, bandpass
// and highpass outputs. Software loads g = tan(pi*fc/fs) (Q5.20), the damping
// r (Q1.16) and h = 1/(1+2rg+g*g) (Q1.24) while the filter is idle; both
// integrator states clear at reset. The result becomes valid, and the input
// ready again, in the same cycle once a request has been through every step,
// so a new request is taken only after the last result has been loaded. The
// steps are four dependent products that share one 24x26 multiplier, two
// passes each, plus the add/saturate steps between them.
// The result sits in an output register; a stalled output only holds the
// filter in its final step.
module tpt_state_variable_filter_top import tsvf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsvf_in_if.sink               sample_ch,
  tsvf_out_if.source            result_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  tsvf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_ch.valid),
    .in_ready_o (sample_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsvf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_ch.sample_in),
    .out_ready_i (result_ch.ready),
    .out_valid_o (result_ch.valid),
    .lowpass_o   (result_ch.lowpass_out),
    .bandpass_o  (result_ch.bandpass_out),
    .highpass_o  (result_ch.highpass_out)
  );

endmodule

// ===== test/tsvf_checker.sv =====
`timescale 1ns / 100ps

module tsvf_checker import tsvf_pkg::*; #(
  parameter int SAMPLE_W = 24,
  parameter int STATE_W  = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [SAMPLE_W-1:0] lowpass_i,
  input  logic signed [SAMPLE_W-1:0] bandpass_i,
  input  logic signed [SAMPLE_W-1:0] highpass_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lowpass;
    logic signed [SAMPLE_W-1:0] bandpass;
    logic signed [SAMPLE_W-1:0] highpass;
  } bands_t;

  bands_t             expected_bands_q[$];
  logic [GAIN_W-1:0]  gain_q;
  logic [DAMP_W-1:0]  damp_q;
  logic [SCALE_W-1:0] scale_q;
  wide_t              integ1_q;
  wide_t              integ2_q;
  int                 mismatches = 0;

  // |a| * coef scaled down by sh bits, rounded half away from zero
  function automatic wide_t round_mul(wide_t a, logic [31:0] coef, int sh);
    logic [95:0] mag;
    logic [95:0] prod;
    mag  = a[95] ? -a : a;
    prod = (mag * 96'(coef) + (96'd1 << (sh - 1))) >> sh;
    return a[95] ? -$signed(prod) : $signed(prod);
  endfunction

  function automatic wide_t saturate(wide_t v, int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic bands_t filter_step(logic signed [SAMPLE_W-1:0] sample);
    logic [31:0] coef;
    wide_t       acc, hp, bp, lp, s1_next, s2_next;
    bands_t      bands;
    coef    = (32'(damp_q) << DAMP_SHIFT) + 32'(gain_q);
    acc     = wide_t'(sample) - round_mul(integ1_q, coef, GAIN_FRAC) - integ2_q;
    hp      = saturate(round_mul(acc, 32'(scale_q), SCALE_FRAC), STATE_W);
    bp      = saturate(round_mul(hp, 32'(gain_q), GAIN_FRAC) + integ1_q, STATE_W);
    s1_next = saturate(round_mul(hp, 32'(gain_q), GAIN_FRAC) + bp, STATE_W);
    lp      = saturate(round_mul(bp, 32'(gain_q), GAIN_FRAC) + integ2_q, STATE_W);
    s2_next = saturate(round_mul(bp, 32'(gain_q), GAIN_FRAC) + lp, STATE_W);
    integ1_q = s1_next;
    integ2_q = s2_next;
    bands.lowpass  = SAMPLE_W'(saturate(lp, SAMPLE_W));
    bands.bandpass = SAMPLE_W'(saturate(bp, SAMPLE_W));
    bands.highpass = SAMPLE_W'(saturate(hp, SAMPLE_W));
    return bands;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bands_t got;
    bands_t want;
    if (!rst_ni) begin
      gain_q   = GAIN_RST;
      damp_q   = DAMP_RST;
      scale_q  = SCALE_RST;
      integ1_q = '0;
      integ2_q = '0;
      expected_bands_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CUTOFF_GAIN:    gain_q  = cfg_data_i[GAIN_W-1:0];
          REG_DAMPING:        damp_q  = cfg_data_i[DAMP_W-1:0];
          REG_FEEDBACK_SCALE: scale_q = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      // result side first: it always belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        got = {lowpass_i, bandpass_i, highpass_i};
        if (expected_bands_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: lp %0d bp %0d hp %0d",
                     got.lowpass, got.bandpass, got.highpass);
        end else begin
          want = expected_bands_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected lp %0d bp %0d hp %0d, got lp %0d bp %0d hp %0d",
                       want.lowpass, want.bandpass, want.highpass,
                       got.lowpass, got.bandpass, got.highpass);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_bands_q.push_back(filter_step(sample_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_bands_q.size();
  end

endmodule

// ===== test/tb_tpt_state_variable_filter_top.sv =====
`timescale 1ns / 100ps

module tb_tpt_state_variable_filter_top import tsvf_pkg::*;;

  localparam int SAMPLE_W       = 24;
  localparam int STATE_W        = 40;
  localparam int RANDOM_ITEMS   = 1880;
  localparam int DRAIN_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic [CFG_DATA_W-1:0] GAIN_ONE  = 25'd1048576;
  localparam logic [CFG_DATA_W-1:0] GAIN_TOP  = 25'd16777216;
  localparam logic [CFG_DATA_W-1:0] DAMP_ONE  = 25'd65536;
  localparam logic [CFG_DATA_W-1:0] DAMP_LOW  = 25'd33;
  localparam logic [CFG_DATA_W-1:0] SCALE_ONE = 25'd16777216;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  ready_q = 1'b0;
  logic                  idle_on = 1'b0;
  int                    stall_left = 0;
  int                    quiet_cycles = 0;
  int                    fail_count;
  int                    pending;

  tsvf_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) sample_if ();
  tsvf_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) result_if ();

  assign result_if.ready = ready_q;

  tpt_state_variable_filter_top #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .STATE_WIDTH (STATE_W)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_ch (sample_if),
    .result_ch (result_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  tsvf_checker #(
    .SAMPLE_W(SAMPLE_W),
    .STATE_W (STATE_W)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (sample_if.valid),
    .in_ready_i  (sample_if.ready),
    .sample_i    (sample_if.sample_in),
    .out_valid_i (result_if.valid),
    .out_ready_i (result_if.ready),
    .lowpass_i   (result_if.lowpass_out),
    .bandpass_i  (result_if.bandpass_out),
    .highpass_i  (result_if.highpass_out),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result-side backpressure: mostly ready, short stalls and the odd long one
  always @(posedge clk_i) begin
    int roll;
    roll = $urandom_range(0, 99);
    if (stall_left > 0) stall_left--;
    else if (idle_on && roll < 10) stall_left = $urandom_range(1, 4);
    else if (idle_on && roll < 13) stall_left = $urandom_range(20, 80);
    ready_q <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // h = 1/(1 + 2rg + g^2) in Q1.24, matching what software would load
  function automatic logic [CFG_DATA_W-1:0] scale_for(logic [CFG_DATA_W-1:0] g_code,
                                                      logic [DAMP_W-1:0] r_code);
    real g, r, h;
    int  h_int;
    g     = real'(g_code) / 1048576.0;
    r     = real'(r_code) / 65536.0;
    h     = 1.0 / (1.0 + 2.0 * r * g + g * g);
    h_int = $rtoi(h * 16777216.0 + 0.5);
    if (h_int > 16777216) h_int = 16777216;
    if (h_int < 1) h_int = 1;
    return CFG_DATA_W'(h_int);
  endfunction

  task automatic send_sample(logic signed [SAMPLE_W-1:0] x, int gap);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid     <= 1'b1;
    sample_if.sample_in <= x;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    // the pending count is registered, so it trails the checker's queue
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // the unused index gets a random write each time; it must be ignored
  task automatic write_regs(logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] r,
                            logic [CFG_DATA_W-1:0] h);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_CUTOFF_GAIN;
    cfg_data <= g;
    @(posedge clk_i);
    cfg_idx  <= REG_DAMPING;
    cfg_data <= r;
    @(posedge clk_i);
    cfg_idx  <= REG_FEEDBACK_SCALE;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_idx  <= REG_UNUSED;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] amp;
    logic [CFG_DATA_W-1:0]      g_code, r_data, h_code;
    logic [DAMP_W-1:0]          r_code;
    int                         sent, n, kind, roll, gap, period, v;

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_CUTOFF_GAIN;
    cfg_data            = '0;
    sample_if.valid     = 1'b0;
    sample_if.sample_in = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: g = 0 so highpass passes the input straight through
    send_sample(SAMPLE_MAX, 0);
    send_sample(SAMPLE_MIN, 0);
    send_sample('0, 0);
    send_sample(24'sd1, 0);
    send_sample(-24'sd1, 0);
    wait_idle();

    // very low damping: full-scale steps ring hard and the outputs clip
    write_regs(GAIN_ONE, DAMP_LOW, scale_for(GAIN_ONE, DAMP_LOW[DAMP_W-1:0]));
    repeat (6) send_sample(SAMPLE_MAX, 0);
    repeat (6) send_sample(SAMPLE_MIN, 0);
    wait_idle();

    // gain far out of range, zero damping: the integrators hit their rails
    write_regs({CFG_DATA_W{1'b1}}, '0, SCALE_ONE);
    send_sample(SAMPLE_MAX, 0);
    send_sample(SAMPLE_MIN, 0);
    send_sample(SAMPLE_MAX, 0);
    send_sample(SAMPLE_MIN, 0);
    wait_idle();

    // h of zero zeroes the highpass path
    write_regs(GAIN_TOP, DAMP_ONE, '0);
    send_sample(SAMPLE_MAX, 0);
    send_sample(-24'sd1, 0);
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: g_code = CFG_DATA_W'($urandom_range(1, 1048576));
          5, 6, 7:       g_code = CFG_DATA_W'($urandom_range(1048576, 16777216));
          8:             g_code = GAIN_TOP;
          default:       g_code = '0;
        endcase
        case ($urandom_range(0, 9))
          0, 1:    r_code = DAMP_LOW[DAMP_W-1:0];
          2:       r_code = DAMP_ONE[DAMP_W-1:0];
          default: r_code = DAMP_W'($urandom_range(33, 65536));
        endcase
        h_code = scale_for(g_code, r_code);
      end else begin
        g_code = CFG_DATA_W'($urandom);
        r_code = DAMP_W'($urandom);
        h_code = CFG_DATA_W'($urandom);
      end
      // the damping register is narrower than the data bus: upper bits must drop
      if ($urandom_range(0, 3) == 0) r_data = {8'($urandom), r_code};
      else r_data = CFG_DATA_W'(r_code);
      write_regs(g_code, r_data, h_code);

      idle_on <= ($urandom_range(0, 3) != 0);
      kind   = $urandom_range(0, 5);
      period = $urandom_range(1, 40);
      amp    = SAMPLE_W'($urandom_range(0, 8388607));
      n      = $urandom_range(20, 150);
      for (int i = 0; i < n; i++) begin
        case (kind)
          0, 1: x = SAMPLE_W'($urandom);
          2: begin
            v = int'($urandom_range(0, 8191)) - 4096;
            x = SAMPLE_W'(v);
          end
          3: begin
            case ($urandom_range(0, 3))
              0:       x = SAMPLE_MAX;
              1:       x = SAMPLE_MIN;
              2:       x = '0;
              default: x = -24'sd1;
            endcase
          end
          4: x = ((i / period) % 2) ? amp : -amp;
          default: x = $urandom_range(0, 1) ? SAMPLE_W'($urandom)
                                            : ($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
        endcase
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 65) gap = 0;
        else if (roll < 93) gap = $urandom_range(1, 4);
        else gap = $urandom_range(10, 60);
        send_sample(x, gap);
      end
      sent += n;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== tpt_state_variable_filter_top.f =====
rtl/core/tsvf_pkg.sv
rtl/core/tsvf_in_if.sv
rtl/core/tsvf_out_if.sv
rtl/core/tsvf_ctrl.sv
rtl/core/tsvf_datapath.sv
rtl/core/tpt_state_variable_filter_top.sv
test/tsvf_checker.sv
test/tb_tpt_state_variable_filter_top.sv
